/* design/clock_rate_skew_converter_defines.svh */
// Assertion macros shared by the clock rate skew converter modules.
`ifndef CLOCK_RATE_SKEW_CONVERTER_DEFINES_SVH
`define CLOCK_RATE_SKEW_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define CRSC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crsc: same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define CRSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crsc: next-cycle check failed");

`endif

/* design/crsc_pkg.sv */
// Types and fixed constants shared by the clock rate skew converter files.
`default_nettype none

package crsc_pkg;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV,
      ST_FINISH
   } crsc_state_type;

   // Status returned by the iterative divider.
   typedef struct packed {
      logic busy;
      logic done;
   } crsc_div_status_type;

   // Operation codes of the func field.
   localparam logic FUNC_SYNC    = 1'b0;
   localparam logic FUNC_CONVERT = 1'b1;

   // The divider retires one quotient bit of a 128-bit dividend per cycle.
   localparam int unsigned DIV_STEPS = 128;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Four 32x32 partial products; the counter runs one past the last to drain.
   localparam logic [2:0] MUL_LAST = 3'd4;

endpackage

`default_nettype wire

/* design/crsc_if.sv */
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface crsc_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [63:0] local_time;
   logic [63:0] civil_time;

   modport source (output valid, output func, output local_time, output civil_time,
                   input ready);
   modport sink (input valid, input func, input local_time, input civil_time,
                 output ready);
endinterface

interface crsc_rsp_if;
   logic               valid;
   logic               ready;
   logic [63:0]        civil_result;
   logic signed [31:0] rate_now;
   logic               is_synced;

   modport source (output valid, output civil_result, output rate_now, output is_synced,
                   input ready);
   modport sink (input valid, input civil_result, input rate_now, input is_synced,
                 output ready);
endinterface

`default_nettype wire

/* design/crsc_div.sv */
// Restoring 128-by-64 unsigned divider, one quotient bit per cycle.
`default_nettype none

`include "clock_rate_skew_converter_defines.svh"

module crsc_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [127:0]                  dividend,
   input  wire logic [63:0]                   divisor,
   output crsc_pkg::crsc_div_status_type      status,
   output logic [127:0]                       quotient
);

   logic [127:0]                    work_ff, work_in;
   logic [63:0]                     rem_ff, rem_in;
   logic [63:0]                     divisor_ff, divisor_in;
   logic [crsc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;

   logic [64:0] partial;
   logic [65:0] diff;
   logic        fits;

   // The dividend shifts out at the top while quotient bits enter at the bottom.
   assign partial = {rem_ff, work_ff[127]};
   assign diff    = {1'b0, partial} - {2'b00, divisor_ff};
   assign fits    = ~diff[65];

   always_comb begin
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      if (start) begin
         work_in    = dividend;
         rem_in     = 64'd0;
         divisor_in = divisor;
         cnt_in     = crsc_pkg::DIV_CNT_W'(crsc_pkg::DIV_STEPS - 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[126:0], fits};
         rem_in  = fits ? diff[63:0] : partial[63:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = busy_ff && (cnt_ff == '0);
   assign quotient    = work_ff;

   `CRSC_ASSERT_IMP(a_div_no_restart, start, !busy_ff)
   `CRSC_ASSERT_NEXT(a_div_start_busy, start, busy_ff && (rem_ff == 64'd0))
   `CRSC_ASSERT_IMP(a_div_rem_below, busy_ff, rem_ff < divisor_ff)

endmodule

`default_nettype wire

/* design/clock_rate_skew_converter.sv */
// Top level of the clock rate skew converter: sync point, rate and sequencer.
//
//   channel   direction  handshake            payload
//   req_chan  in         valid/ready          func, local_time, civil_time
//   rsp_chan  out        valid/ready          civil_result, rate_now, is_synced
//
// A transaction with arithmetic passes through setup, the 32x32 multiplier, a divider load,
// the one-bit-per-cycle divider and the commit; the block takes the next request only after
// it has returned to idle. Without arithmetic (not synced, or a sync whose local time has
// not advanced) a transaction goes from setup straight to the commit. Reset is synchronous
// and restores unity rate; a waiting response stalls only the commit.
`default_nettype none

`include "clock_rate_skew_converter_defines.svh"

module clock_rate_skew_converter #(
   parameter int unsigned RATE_SCALE = 65536,
   parameter int unsigned RATE_WIDTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   crsc_req_if.sink  req_chan,
   crsc_rsp_if.source rsp_chan
);

   localparam int unsigned RateRegW  = (RATE_WIDTH > 32) ? RATE_WIDTH : 32;
   localparam logic [63:0] ScaleWide = 64'(RATE_SCALE);
   localparam logic [63:0] RateLim   = 64'd1 << (RATE_WIDTH - 1);

   crsc_pkg::crsc_state_type state_ff, state_in;

   logic [63:0]                 sync_civil_ff, sync_civil_in;
   logic [63:0]                 sync_local_ff, sync_local_in;
   logic signed [RateRegW-1:0]  rate_ff, rate_in;

   logic        func_ff, func_in;
   logic [63:0] local_ff, local_in;
   logic [63:0] civil_ff, civil_in;
   logic [63:0] dl_ff, dl_in;
   logic [63:0] dc_ff, dc_in;
   logic        neg_ff, neg_in;
   logic        skip_ff, skip_in;
   logic [63:0] op_a_ff, op_a_in;
   logic [63:0] op_b_ff, op_b_in;
   logic [2:0]  mul_cnt_ff, mul_cnt_in;
   logic [63:0] pp_ff, pp_in;
   logic [1:0]  pp_idx_ff, pp_idx_in;
   logic [127:0] acc_ff, acc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_civil_ff, rsp_civil_in;
   logic signed [31:0] rsp_rate_ff, rsp_rate_in;
   logic               rsp_synced_ff, rsp_synced_in;

   logic req_accept;
   logic commit;
   logic div_start;
   logic mul_step;

   crsc_pkg::crsc_div_status_type div_status;
   logic [127:0] div_quotient;
   logic [63:0]  div_divisor;

   logic [63:0]  rate_wide;
   logic [63:0]  rate_mag;
   logic [63:0]  dl_mag;
   logic [63:0]  dc_mag;
   logic [31:0]  a_part;
   logic [31:0]  b_part;
   logic [127:0] pp_shifted;
   logic [63:0]  q_lo;
   logic         q_fits;
   logic [63:0]  q_signed;
   logic [63:0]  conv_sum;
   logic         slot_free;

   assign rate_wide = 64'(rate_ff);
   assign rate_mag  = rate_wide[63] ? (64'd0 - rate_wide) : rate_wide;
   assign dl_mag    = dl_ff[63] ? (64'd0 - dl_ff) : dl_ff;
   assign dc_mag    = dc_ff[63] ? (64'd0 - dc_ff) : dc_ff;

   assign a_part = mul_cnt_ff[1] ? op_a_ff[63:32] : op_a_ff[31:0];
   assign b_part = mul_cnt_ff[0] ? op_b_ff[63:32] : op_b_ff[31:0];

   always_comb begin
      case (pp_idx_ff) inside
         2'd0:       pp_shifted = {64'd0, pp_ff};
         2'd1, 2'd2: pp_shifted = {32'd0, pp_ff, 32'd0};
         default:    pp_shifted = {pp_ff, 64'd0};
      endcase
   end

   // Quotient post-processing: the rate limit check for syncs and the signed
   // adjustment for conversions.
   assign q_lo     = div_quotient[63:0];
   assign q_fits   = (div_quotient[127:64] == 64'd0) &&
                     (neg_ff ? (q_lo <= RateLim) : (q_lo < RateLim));
   assign q_signed = neg_ff ? (64'd0 - q_lo) : q_lo;
   assign conv_sum = neg_ff ? (sync_civil_ff - q_lo) : (sync_civil_ff + q_lo);

   assign div_divisor = (func_ff == crsc_pkg::FUNC_CONVERT) ? ScaleWide : dl_ff;
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;

   crsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         crsc_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = crsc_pkg::ST_SETUP;
            end
         end
         crsc_pkg::ST_SETUP: begin
            state_in = skip_in ? crsc_pkg::ST_FINISH : crsc_pkg::ST_MUL;
         end
         crsc_pkg::ST_MUL: begin
            if (mul_cnt_ff == crsc_pkg::MUL_LAST) begin
               state_in = crsc_pkg::ST_DIV_GO;
            end
         end
         crsc_pkg::ST_DIV_GO: begin
            state_in = crsc_pkg::ST_DIV;
         end
         crsc_pkg::ST_DIV: begin
            if (div_status.done) begin
               state_in = crsc_pkg::ST_FINISH;
            end
         end
         crsc_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = crsc_pkg::ST_IDLE;
            end
         end
         default: state_in = crsc_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_chan.ready = 1'b0;
      div_start      = 1'b0;
      mul_step       = 1'b0;
      commit         = 1'b0;
      unique case (state_ff)
         crsc_pkg::ST_IDLE:   req_chan.ready = 1'b1;
         crsc_pkg::ST_SETUP:  ;
         crsc_pkg::ST_MUL:    mul_step = 1'b1;
         crsc_pkg::ST_DIV_GO: div_start = 1'b1;
         crsc_pkg::ST_DIV:    ;
         crsc_pkg::ST_FINISH: commit = slot_free;
         default:             ;
      endcase
   end

   assign req_accept = req_chan.valid && req_chan.ready;

   // Datapath next values.
   always_comb begin
      func_in       = func_ff;
      local_in      = local_ff;
      civil_in      = civil_ff;
      dl_in         = dl_ff;
      dc_in         = dc_ff;
      neg_in        = neg_ff;
      skip_in       = skip_ff;
      op_a_in       = op_a_ff;
      op_b_in       = op_b_ff;
      mul_cnt_in    = mul_cnt_ff;
      pp_in         = pp_ff;
      pp_idx_in     = pp_idx_ff;
      acc_in        = acc_ff;
      sync_civil_in = sync_civil_ff;
      sync_local_in = sync_local_ff;
      rate_in       = rate_ff;
      rsp_civil_in  = rsp_civil_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_synced_in = rsp_synced_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      if (req_accept) begin
         func_in  = req_chan.func;
         local_in = req_chan.local_time;
         civil_in = req_chan.civil_time;
         dl_in    = req_chan.local_time - sync_local_ff;
         dc_in    = req_chan.civil_time - sync_civil_ff;
      end

      if (state_ff == crsc_pkg::ST_SETUP) begin
         mul_cnt_in = 3'd0;
         acc_in     = 128'd0;
         if (func_ff == crsc_pkg::FUNC_SYNC) begin
            // No estimate without an earlier sync point or with a local time
            // that has not moved forward.
            skip_in = (sync_civil_ff == 64'd0) || (dl_ff == 64'd0) || dl_ff[63];
            op_a_in = dc_mag;
            op_b_in = ScaleWide;
            neg_in  = dc_ff[63];
         end else begin
            skip_in = (sync_civil_ff == 64'd0);
            op_a_in = dl_mag;
            op_b_in = rate_mag;
            neg_in  = dl_ff[63] ^ rate_wide[63];
         end
      end

      if (mul_step) begin
         mul_cnt_in = mul_cnt_ff + 3'd1;
         if (mul_cnt_ff != crsc_pkg::MUL_LAST) begin
            pp_in     = a_part * b_part;
            pp_idx_in = mul_cnt_ff[1:0];
         end
         if (mul_cnt_ff != 3'd0) begin
            acc_in = acc_ff + pp_shifted;
         end
      end

      if (commit) begin
         rsp_valid_in = 1'b1;
         if (func_ff == crsc_pkg::FUNC_SYNC) begin
            if (sync_civil_ff != 64'd0) begin
               if (!skip_ff && q_fits) begin
                  rate_in = q_signed[RateRegW-1:0];
               end else begin
                  rate_in = RateRegW'(RATE_SCALE);
               end
            end
            sync_civil_in = civil_ff;
            sync_local_in = local_ff;
            rsp_civil_in  = civil_ff;
            rsp_synced_in = (civil_ff != 64'd0);
         end else begin
            rsp_civil_in  = skip_ff ? local_ff : conv_sum;
            rsp_synced_in = (sync_civil_ff != 64'd0);
         end
         rsp_rate_in = rate_in[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= crsc_pkg::ST_IDLE;
         sync_civil_ff <= 64'd0;
         sync_local_ff <= 64'd0;
         rate_ff       <= RateRegW'(RATE_SCALE);
         rsp_valid_ff  <= 1'b0;
         mul_cnt_ff    <= 3'd0;
      end else begin
         state_ff      <= state_in;
         sync_civil_ff <= sync_civil_in;
         sync_local_ff <= sync_local_in;
         rate_ff       <= rate_in;
         rsp_valid_ff  <= rsp_valid_in;
         mul_cnt_ff    <= mul_cnt_in;
      end
      func_ff       <= func_in;
      local_ff      <= local_in;
      civil_ff      <= civil_in;
      dl_ff         <= dl_in;
      dc_ff         <= dc_in;
      neg_ff        <= neg_in;
      skip_ff       <= skip_in;
      op_a_ff       <= op_a_in;
      op_b_ff       <= op_b_in;
      pp_ff         <= pp_in;
      pp_idx_ff     <= pp_idx_in;
      acc_ff        <= acc_in;
      rsp_civil_ff  <= rsp_civil_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_synced_ff <= rsp_synced_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.civil_result = rsp_civil_ff;
   assign rsp_chan.rate_now     = rsp_rate_ff;
   assign rsp_chan.is_synced    = rsp_synced_ff;

   `CRSC_ASSERT_IMP(a_div_running, state_ff == crsc_pkg::ST_DIV, div_status.busy)
   `CRSC_ASSERT_IMP(a_mul_bound, state_ff == crsc_pkg::ST_MUL, mul_cnt_ff <= crsc_pkg::MUL_LAST)
   `CRSC_ASSERT_NEXT(a_sync_hold, state_ff != crsc_pkg::ST_FINISH, $stable({sync_local_ff, sync_civil_ff}))
   `CRSC_ASSERT_NEXT(a_commit_shows, commit, rsp_valid_ff)

endmodule

`default_nettype wire

/* tb/sv/tb_clock_rate_skew_converter.sv */
// Self-checking testbench for the clock rate skew converter.
`default_nettype none

module tb_clock_rate_skew_converter;

   localparam int unsigned SCALE = 65536;
   localparam int RANDOM_ITEMS = 1500;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 160;

   typedef struct packed {
      logic        func;
      logic [63:0] local_time;
      logic [63:0] civil_time;
   } time_req_type;

   typedef struct packed {
      logic [63:0] civil_result;
      logic [31:0] rate_now;
      logic        is_synced;
   } time_rsp_type;

   logic clock;
   logic reset;

   crsc_req_if req_chan ();
   crsc_rsp_if rsp_chan ();

   clock_rate_skew_converter #(
      .RATE_SCALE (SCALE),
      .RATE_WIDTH (32)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   time_req_type pending_reqs[$];
   time_rsp_type expected_times[$];
   time_req_type offered;
   int          queued_total;
   int          accepted;
   int          responses;
   int          mismatches;
   int          send_gap;
   int          recv_stall;
   logic        calm;
   logic        hold_rsp;

   // Predicted state of the block.
   logic [63:0]        anchor_civil;
   logic [63:0]        anchor_local;
   logic signed [31:0] skew_rate;

   int sync_count;
   int convert_count;
   int unity_fallbacks;
   int passthroughs;

   always #5 clock = ~clock;

   function automatic logic [63:0] magnitude64(logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Random value of random bit length, so small and large spans both show up.
   function automatic logic [63:0] rand_span();
      return rand64() >> $urandom_range(0, 63);
   endfunction

   task automatic push_req(logic func, logic [63:0] local_t, logic [63:0] civil_t);
      time_req_type r;
      r.func = func;
      r.local_time = local_t;
      r.civil_time = civil_t;
      pending_reqs.push_back(r);
      queued_total++;
   endtask

   task automatic advance_clock_model(input time_req_type r, output time_rsp_type rsp);
      logic [63:0]  delta_local;
      logic [63:0]  delta_civil;
      logic [63:0]  rate_ext;
      logic [63:0]  adjust;
      logic [127:0] product;
      logic [127:0] quotient;
      logic         neg;
      logic         fits;
      if (r.func == crsc_pkg::FUNC_SYNC) begin
         sync_count++;
         if (anchor_civil != 0) begin
            delta_local = r.local_time - anchor_local;
            skew_rate = SCALE;
            fits = 1'b0;
            if (delta_local != 0 && !delta_local[63]) begin
               delta_civil = r.civil_time - anchor_civil;
               neg = delta_civil[63];
               product = {64'd0, magnitude64(delta_civil)} * 128'(SCALE);
               quotient = product / {64'd0, delta_local};
               // The negative range reaches one step further than the positive one.
               if (neg ? quotient <= 128'h8000_0000 : quotient < 128'h8000_0000) begin
                  skew_rate = neg ? -quotient[31:0] : quotient[31:0];
                  fits = 1'b1;
               end
            end
            if (!fits) unity_fallbacks++;
         end
         anchor_civil = r.civil_time;
         anchor_local = r.local_time;
         rsp.civil_result = anchor_civil;
      end else begin
         convert_count++;
         if (anchor_civil == 0) begin
            passthroughs++;
            rsp.civil_result = r.local_time;
         end else begin
            delta_local = r.local_time - anchor_local;
            rate_ext = {{32{skew_rate[31]}}, skew_rate};
            neg = delta_local[63] ^ rate_ext[63];
            product = {64'd0, magnitude64(delta_local)} * {64'd0, magnitude64(rate_ext)};
            quotient = product / 128'(SCALE);
            adjust = neg ? -quotient[63:0] : quotient[63:0];
            rsp.civil_result = anchor_civil + adjust;
         end
      end
      rsp.rate_now = skew_rate;
      rsp.is_synced = (anchor_civil != 0);
   endtask

   // Request driver.
   always @(posedge clock) begin
      time_rsp_type predicted;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            advance_clock_model(offered, predicted);
            expected_times.push_back(predicted);
            accepted++;
         end
         if (req_chan.valid && !req_chan.ready) begin
            // Hold the current transaction until it is taken.
         end else if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            offered = pending_reqs.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.func <= offered.func;
            req_chan.local_time <= offered.local_time;
            req_chan.civil_time <= offered.civil_time;
            if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
         end else begin
            req_chan.valid <= 1'b0;
         end
         calm <= (pending_reqs.size() < 120);
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      time_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            responses++;
            if (expected_times.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with no transaction outstanding", responses);
            end else begin
               want = expected_times.pop_front();
               if (rsp_chan.civil_result !== want.civil_result ||
                   rsp_chan.rate_now !== want.rate_now ||
                   rsp_chan.is_synced !== want.is_synced) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response %0d: expected civil %h rate %0d synced %b",
                              responses, want.civil_result, $signed(want.rate_now),
                              want.is_synced);
                     $display("response %0d: got      civil %h rate %0d synced %b",
                              responses, rsp_chan.civil_result,
                              $signed(rsp_chan.rate_now), rsp_chan.is_synced);
                  end
               end
            end
         end
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 14);
         end
      end
   end

   // One long receiver hold-off so the block fills up and backs up its input.
   initial begin
      hold_rsp = 1'b0;
      while (accepted < 300) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #15_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [63:0]         base_local;
      logic [63:0]         base_civil;
      logic [63:0]         stride;
      logic [63:0]         offset;
      logic [63:0]         c12;
      longint              drift;
      logic signed [127:0] wide_stride;
      logic signed [127:0] wide_drift;
      logic signed [127:0] scaled_delta;

      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = crsc_pkg::FUNC_SYNC;
      req_chan.local_time = '0;
      req_chan.civil_time = '0;
      rsp_chan.ready = 1'b0;
      calm = 1'b0;
      offered = '0;
      queued_total = 0;
      accepted = 0;
      responses = 0;
      mismatches = 0;
      anchor_civil = '0;
      anchor_local = '0;
      skew_rate = SCALE;
      sync_count = 0;
      convert_count = 0;
      unity_fallbacks = 0;
      passthroughs = 0;

      // Directed: pass-through before any sync, then every rate path.
      c12 = 64'd7_131_072 + (64'd1 << 40);
      push_req(crsc_pkg::FUNC_CONVERT, 64'd0, 64'd0);
      push_req(crsc_pkg::FUNC_CONVERT, '1, '1);
      // Civil time zero stays unsynced, then the first sync keeps the rate.
      push_req(crsc_pkg::FUNC_SYNC, 64'd1000, 64'd0);
      push_req(crsc_pkg::FUNC_SYNC, 64'd1000, 64'd5_000_000);
      push_req(crsc_pkg::FUNC_CONVERT, 64'd1000 + 64'd65536, 64'd0);
      push_req(crsc_pkg::FUNC_CONVERT, 64'd0, 64'd0);               // local before the sync
      push_req(crsc_pkg::FUNC_SYNC, 64'd1000, 64'd6_000_000);       // local did not advance
      push_req(crsc_pkg::FUNC_SYNC, 64'd500, 64'd7_000_000);        // local went backward
      push_req(crsc_pkg::FUNC_SYNC, 64'd66036, 64'd7_131_072);      // rate of two
      push_req(crsc_pkg::FUNC_CONVERT, '1, 64'd0);
      push_req(crsc_pkg::FUNC_CONVERT, 64'd66036 + (64'd1 << 62), 64'd0);
      push_req(crsc_pkg::FUNC_SYNC, 64'd66037, c12);                // quotient overflows
      push_req(crsc_pkg::FUNC_SYNC, 64'd131573, c12 - (64'd1 << 31)); // most negative rate
      push_req(crsc_pkg::FUNC_CONVERT, 64'd131573 + 64'h7FFF_FFFF_FFFF_FFFF, '1);
      push_req(crsc_pkg::FUNC_CONVERT, 64'd131573 + 64'h8000_0000_0000_0000, '1);
      push_req(crsc_pkg::FUNC_SYNC, 64'd197109, c12);               // one past the top
      push_req(crsc_pkg::FUNC_SYNC, 64'd197112, c12 - 64'd1);       // truncation toward zero
      push_req(crsc_pkg::FUNC_CONVERT, 64'd197212, 64'd0);
      push_req(crsc_pkg::FUNC_SYNC, '1, '1);
      push_req(crsc_pkg::FUNC_SYNC, 64'd9, 64'd0);                  // re-estimates, unsyncs
      push_req(crsc_pkg::FUNC_CONVERT, 64'd12345, '1);

      // Random: mostly chains of sync points with plausible drift, plus noise.
      while (queued_total < RANDOM_ITEMS + 21) begin
         if ($urandom_range(0, 99) < 80) begin
            base_local = rand_span();
            base_civil = rand64();
            push_req(crsc_pkg::FUNC_SYNC, base_local, base_civil);
            repeat ($urandom_range(1, 5)) begin
               stride = rand_span();
               case ($urandom_range(0, 3))
                  0: drift = 63536 + longint'($urandom_range(0, 4000));
                  1: drift = longint'($urandom_range(0, 1 << 20));
                  2: drift = $signed(rand64()) >>> $urandom_range(0, 63);
                  default: drift = -longint'($urandom_range(0, 1 << 18));
               endcase
               wide_stride = $signed({64'd0, stride});
               wide_drift = drift;
               scaled_delta = wide_stride * wide_drift;
               base_local = base_local + stride;
               base_civil = base_civil + scaled_delta[79:16];
               push_req(crsc_pkg::FUNC_SYNC, base_local, base_civil);
               repeat ($urandom_range(0, 3)) begin
                  offset = rand_span();
                  push_req(crsc_pkg::FUNC_CONVERT,
                           $urandom_range(0, 1) ? base_local + offset : base_local - offset,
                           rand64());
               end
            end
         end else begin
            push_req(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? rand64() : rand_span(),
                     ($urandom_range(0, 7) == 0) ? 64'd0 : rand64());
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (accepted < queued_total || expected_times.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_times.size() != 0) mismatches++;
      $display("Covered %0d sync and %0d convert transactions, %0d responses checked.",
               sync_count, convert_count, responses);
      $display("Rate fell back to unity %0d times; %0d conversions passed local time through.",
               unity_fallbacks, passthroughs);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
